/* rtl/core/evmnd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmnd_pkg: shared types and constants
// Job codes, front-to-back control groups, back-end states and the fixed
// vertex neighbour table of a hex element.
// ----------------------------------------------------------------------------
package evmnd_pkg;

    localparam int NUM_VERT    = 8;
    localparam int VIDX_W      = 3;
    localparam int DIST_W      = 50;
    localparam int DIMS_W      = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DIMS_W-1:0] DIMS_2     = 2'd2;
    localparam logic [DIMS_W-1:0] DIMS_3     = 2'd3;
    localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_3;

    localparam logic [VIDX_W-1:0] LAST_QUAD_VERT = 3'd3;
    localparam logic [VIDX_W-1:0] LAST_HEX_VERT  = 3'd7;
    localparam logic [1:0]        LAST_QUAD_NBR  = 2'd1;
    localparam logic [1:0]        LAST_HEX_NBR   = 2'd2;

    // one unit of work for the back end
    typedef struct packed {
        logic err;   // bad dimension: one error word, no store access
        logic hex;   // 1: 8 vertices, 3 axes; 0: 4 vertices, 2 axes
    } t_job;

    // vertex store write control from the front end
    typedef struct packed {
        logic              en;
        logic [VIDX_W-1:0] addr;
    } t_wr_ctl;

    // back end status toward the front end
    typedef struct packed {
        logic emit_done;   // last word of an element has been loaded
    } t_be_status;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_ISSUE,
        BE_WAIT,
        BE_OUT
    } t_be_state;

    // neighbour k of vertex v within a hex element (2D uses k 0 and 1)
    function automatic logic [VIDX_W-1:0] nbr_vertex(input logic [VIDX_W-1:0] v,
                                                     input logic [1:0] k);
        logic [3*VIDX_W-1:0] row;
        unique case (v)
            3'd0:    row = {3'd4, 3'd2, 3'd1};
            3'd1:    row = {3'd5, 3'd3, 3'd0};
            3'd2:    row = {3'd6, 3'd3, 3'd0};
            3'd3:    row = {3'd7, 3'd2, 3'd1};
            3'd4:    row = {3'd6, 3'd5, 3'd0};
            3'd5:    row = {3'd7, 3'd4, 3'd1};
            3'd6:    row = {3'd7, 3'd4, 3'd2};
            default: row = {3'd6, 3'd5, 3'd3};
        endcase
        unique case (k)
            2'd0:    return row[VIDX_W-1:0];
            2'd1:    return row[2*VIDX_W-1:VIDX_W];
            default: return row[3*VIDX_W-1:2*VIDX_W];
        endcase
    endfunction

endpackage

/* rtl/core/evmnd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmnd_if: vertex and result stream interfaces
// Valid/ready channels; a word moves at a rising edge with valid and ready.
// ----------------------------------------------------------------------------
interface evmnd_in_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

interface evmnd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  vertex_index;
    logic [49:0] min_sq_distance;
    logic        last_of_element;
    logic        error;

    modport source (output valid, output vertex_index, output min_sq_distance,
                    output last_of_element, output error, input ready);
    modport sink   (input valid, input vertex_index, input min_sq_distance,
                    input last_of_element, input error, output ready);
endinterface

/* rtl/core/evmnd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmnd_front: vertex intake and classification
// Holds the dimension register and vertex count, writes accepted vertices
// into the store and queues emission or error jobs for the back end.
// ----------------------------------------------------------------------------
module evmnd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [evmnd_pkg::DIMS_W-1:0]   i_cfg_wdata,
    evmnd_in_if.sink                       i_in,
    input  logic                           i_q_full,
    input  evmnd_pkg::t_be_status          i_be_status,
    output logic                           o_job_push,
    output evmnd_pkg::t_job                o_job,
    output evmnd_pkg::t_wr_ctl             o_wr
);

    logic [evmnd_pkg::DIMS_W-1:0] r_dims;
    logic [evmnd_pkg::VIDX_W-1:0] r_count;
    logic [evmnd_pkg::VIDX_W-1:0] n_count;
    logic                         r_busy;
    logic                         dims_ok;
    logic                         accept;
    logic                         emit;

    // classify the incoming word
    assign dims_ok = (r_dims == evmnd_pkg::DIMS_2) || (r_dims == evmnd_pkg::DIMS_3);
    assign i_in.ready = !i_q_full && !r_busy;
    assign accept  = i_in.valid && i_in.ready;
    assign n_count = r_count + 3'd1;
    // element complete: count wrapped to zero, or reached four for quads
    assign emit    = (n_count == '0) ||
                     ((r_dims == evmnd_pkg::DIMS_2) && n_count[2]);

    // drive store write and job push
    always_comb begin
        o_wr.en      = accept && dims_ok;
        o_wr.addr    = r_count;
        o_job_push   = accept && (!dims_ok || emit);
        o_job.err    = !dims_ok;
        o_job.hex    = (r_dims == evmnd_pkg::DIMS_3);
    end

    // hold dimension register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= evmnd_pkg::DIMS_RESET;
        end else if (i_cfg_we) begin
            r_dims <= i_cfg_wdata;
        end
    end

    // advance vertex count, block intake while an element is being emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (accept && dims_ok) begin
                if (emit) begin
                    r_count <= '0;
                    r_busy  <= 1'b1;
                end else begin
                    r_count <= n_count;
                end
            end else if (i_be_status.emit_done) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/evmnd_job_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmnd_job_queue: job queue between front and back end
// Small first-in first-out buffer of jobs.
// ----------------------------------------------------------------------------
module evmnd_job_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  evmnd_pkg::t_job i_job,
    input  logic            i_pop,
    output evmnd_pkg::t_job o_job,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = $clog2(evmnd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(evmnd_pkg::QUEUE_DEPTH + 1);

    evmnd_pkg::t_job  r_slot [evmnd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(evmnd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slot[r_rp];

    // store pushed job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(evmnd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(evmnd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

/* rtl/core/evmnd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmnd_back: vertex store and distance engine
// Reads vertex pairs from the store, forms squared distances through a
// four-stage pipeline, keeps the minimum per vertex and loads result words.
// ----------------------------------------------------------------------------
module evmnd_back #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  evmnd_pkg::t_wr_ctl            i_wr,
    input  logic signed [COORD_WIDTH-1:0] i_wr_x,
    input  logic signed [COORD_WIDTH-1:0] i_wr_y,
    input  logic signed [COORD_WIDTH-1:0] i_wr_z,
    input  evmnd_pkg::t_job               i_job,
    input  logic                          i_job_empty,
    output logic                          o_job_pop,
    output evmnd_pkg::t_be_status         o_status,
    evmnd_out_if.source                   o_out
);

    localparam int VW    = evmnd_pkg::VIDX_W;
    localparam int DW    = evmnd_pkg::DIST_W;
    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int SUM_W = SQ_W + 2;
    localparam int EXT_W = (SUM_W > DW) ? SUM_W : DW + 1;

    // vertex store, one entry of three coordinates per vertex
    logic [3*COORD_WIDTH-1:0] r_mem [evmnd_pkg::NUM_VERT];
    logic [3*COORD_WIDTH-1:0] r_rd_a;
    logic [3*COORD_WIDTH-1:0] r_rd_b;
    logic [VW-1:0]            rd_addr_b;

    // sequencer
    evmnd_pkg::t_be_state r_state;
    evmnd_pkg::t_be_state n_state;
    logic [VW-1:0]        r_v;
    logic [VW-1:0]        n_v;
    logic [1:0]           r_k;
    logic [1:0]           n_k;
    logic                 r_err;
    logic                 n_err;
    logic                 r_hex;
    logic                 n_hex;
    logic                 issue;
    logic                 issue_first;
    logic                 issue_last;
    logic                 load_out;
    logic                 best_clr;
    logic                 out_free;
    logic [VW-1:0]        v_last;
    logic [1:0]           k_last;

    // pipeline
    logic                         r_p1, r_p2, r_p3;
    logic                         r_first1, r_first2, r_first3;
    logic                         r_last1, r_last2, r_last3;
    logic [COORD_WIDTH-1:0]       r_ad [3];
    logic [SQ_W-1:0]              r_sq [3];
    logic [COORD_WIDTH-1:0]       ad [3];
    logic [SUM_W-1:0]             sum;
    logic [EXT_W-1:0]             sum_ext;
    logic [DW-1:0]                pair_dist;
    logic [DW-1:0]                r_best;
    logic                         r_best_ok;

    // output register
    logic                         r_ovalid;
    logic [VW-1:0]                r_oidx;
    logic [DW-1:0]                r_odist;
    logic                         r_olast;
    logic                         r_oerr;

    assign v_last   = r_hex ? evmnd_pkg::LAST_HEX_VERT : evmnd_pkg::LAST_QUAD_VERT;
    assign k_last   = r_hex ? evmnd_pkg::LAST_HEX_NBR  : evmnd_pkg::LAST_QUAD_NBR;
    assign out_free = !r_ovalid || o_out.ready;
    assign rd_addr_b = evmnd_pkg::nbr_vertex(r_v, r_k);

    // write and read the vertex store
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= {i_wr_z, i_wr_y, i_wr_x};
        end
        r_rd_a <= r_mem[r_v];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // next state of the sequencer
    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_k         = r_k;
        n_err       = r_err;
        n_hex       = r_hex;
        o_job_pop   = 1'b0;
        issue       = 1'b0;
        issue_first = 1'b0;
        issue_last  = 1'b0;
        load_out    = 1'b0;
        best_clr    = 1'b0;
        o_status.emit_done = 1'b0;
        unique case (r_state)
            evmnd_pkg::BE_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_err     = i_job.err;
                    n_hex     = i_job.hex;
                    n_v       = '0;
                    n_k       = '0;
                    n_state   = i_job.err ? evmnd_pkg::BE_OUT : evmnd_pkg::BE_ISSUE;
                end
            end
            evmnd_pkg::BE_ISSUE: begin
                issue       = 1'b1;
                issue_first = (r_k == '0);
                issue_last  = (r_k == k_last);
                if (r_k == k_last) begin
                    n_state = evmnd_pkg::BE_WAIT;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            evmnd_pkg::BE_WAIT: begin
                if (r_best_ok) begin
                    best_clr = 1'b1;
                    n_state  = evmnd_pkg::BE_OUT;
                end
            end
            evmnd_pkg::BE_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_err || (r_v == v_last)) begin
                        o_status.emit_done = !r_err;
                        n_state = evmnd_pkg::BE_IDLE;
                    end else begin
                        n_v     = r_v + 3'd1;
                        n_k     = '0;
                        n_state = evmnd_pkg::BE_ISSUE;
                    end
                end
            end
            default: n_state = evmnd_pkg::BE_IDLE;
        endcase
    end

    // hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= evmnd_pkg::BE_IDLE;
            r_v     <= '0;
            r_k     <= '0;
            r_err   <= 1'b0;
            r_hex   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v     <= n_v;
            r_k     <= n_k;
            r_err   <= n_err;
            r_hex   <= n_hex;
        end
    end

    // absolute coordinate differences, z dropped for quads
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [COORD_WIDTH:0] d;
            d = $signed({r_rd_a[a*COORD_WIDTH + COORD_WIDTH-1],
                         r_rd_a[a*COORD_WIDTH +: COORD_WIDTH]}) -
                $signed({r_rd_b[a*COORD_WIDTH + COORD_WIDTH-1],
                         r_rd_b[a*COORD_WIDTH +: COORD_WIDTH]});
            ad[a] = d[COORD_WIDTH] ? COORD_WIDTH'(-d) : d[COORD_WIDTH-1:0];
        end
        if (!r_hex) begin
            ad[2] = '0;
        end
    end

    // sum squares and saturate to the result width
    assign sum       = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    assign sum_ext   = EXT_W'(sum);
    assign pair_dist = (|sum_ext[EXT_W-1:DW]) ? '1 : sum_ext[DW-1:0];

    // advance pipeline valids and tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1      <= 1'b0;
            r_p2      <= 1'b0;
            r_p3      <= 1'b0;
            r_best_ok <= 1'b0;
        end else begin
            r_p1 <= issue;
            r_p2 <= r_p1;
            r_p3 <= r_p2;
            if (r_p3 && r_last3) begin
                r_best_ok <= 1'b1;
            end else if (best_clr) begin
                r_best_ok <= 1'b0;
            end
        end
    end

    // pipeline payload: differences, squares, running minimum
    always_ff @(posedge i_clk) begin
        r_first1 <= issue_first;
        r_last1  <= issue_last;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_first3 <= r_first2;
        r_last3  <= r_last2;
        for (int a = 0; a < 3; a++) begin
            r_ad[a] <= ad[a];
            r_sq[a] <= SQ_W'(r_ad[a]) * SQ_W'(r_ad[a]);
        end
        if (r_p3) begin
            if (r_first3 || (pair_dist < r_best)) begin
                r_best <= pair_dist;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // load result word
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_oidx  <= r_err ? '0 : r_v;
            r_odist <= r_err ? '0 : r_best;
            r_olast <= !r_err && (r_v == v_last);
            r_oerr  <= r_err;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.vertex_index    = r_oidx;
    assign o_out.min_sq_distance = r_odist;
    assign o_out.last_of_element = r_olast;
    assign o_out.error           = r_oerr;

endmodule

/* rtl/core/element_vertex_min_neighbor_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// element_vertex_min_neighbor_distance: per-vertex nearest edge neighbour
// Takes quad or hex vertices one word at a time and, once an element is
// complete, returns one word per vertex with its smallest squared distance
// to the fixed edge neighbours.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one vertex (signed Q12.12 x, y, z) per word, in stored
//   vertex order. i_cfg_we/i_cfg_wdata write the dimension register while
//   the block is idle: 2 selects quads (4 vertices), 3 hexes (8 vertices).
//   o_out returns vertex_index, the Q26.24 squared distance, last_of_element
//   and error. Any other dimension turns each input word into one error word.
//   Loading accepts one vertex per cycle while intake is not stalled. After
//   the last vertex the vertex store is read pair by pair through a
//   four-stage difference/square/sum pipeline, nd pairs per result word
//   (nd = 2 or 3 neighbours); the back end waits for the minimum before it
//   loads the word and moves to the next vertex. Intake stalls while an
//   element is being emitted; an error word bypasses the store and pipeline.
//   A stalled receiver holds the output register and the back end waits.
//   Reset clears counts, queue and output valid and sets dimension 3; the
//   vertex store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module element_vertex_min_neighbor_distance #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [evmnd_pkg::DIMS_W-1:0] i_cfg_wdata,
    evmnd_in_if.sink                     i_in,
    evmnd_out_if.source                  o_out
);

    evmnd_pkg::t_job       job_push_data;
    evmnd_pkg::t_job       job_head;
    evmnd_pkg::t_wr_ctl    wr_ctl;
    evmnd_pkg::t_be_status be_status;
    logic                  job_push;
    logic                  job_pop;
    logic                  q_full;
    logic                  q_empty;

    // intake and classification
    evmnd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .i_be_status (be_status),
        .o_job_push  (job_push),
        .o_job       (job_push_data),
        .o_wr        (wr_ctl)
    );

    // job queue
    evmnd_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_push_data),
        .i_pop   (job_pop),
        .o_job   (job_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // store and distance engine
    evmnd_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr_ctl),
        .i_wr_x      (i_in.coord_x),
        .i_wr_y      (i_in.coord_y),
        .i_wr_z      (i_in.coord_z),
        .i_job       (job_head),
        .i_job_empty (q_empty),
        .o_job_pop   (job_pop),
        .o_status    (be_status),
        .o_out       (o_out)
    );

endmodule
